FILE: sv/ale_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and widths of the array list engine
package ale_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned LEN_W  = 8;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_READ   = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_SORT   = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_RD_WAIT,
    S_INS_CHK,
    S_INS_WR,
    S_DEL_CHK,
    S_DEL_WR,
    S_SORT_CHK,
    S_KEY_WAIT,
    S_CMP_CHK,
    S_CMP,
    S_DONE
  } state_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_CLEAR,
    CMD_SET_RANGE,
    CMD_SET_FULL,
    CMD_RD_POS,
    CMD_TAKE_RD,
    CMD_INS_INIT,
    CMD_SHUP_RD,
    CMD_SHUP_WR,
    CMD_INS_PUT,
    CMD_DEL_INIT,
    CMD_SHDN_RD,
    CMD_SHDN_WR,
    CMD_DEL_DONE,
    CMD_SORT_INIT,
    CMD_KEY_RD,
    CMD_KEY_TAKE,
    CMD_CMP_RD,
    CMD_CMP_SHIFT,
    CMD_KEY_PUT,
    CMD_FINISH
  } cmd_e;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            pos_bad;
    logic            pos_bad_ins;
    logic            idx_above;
    logic            idx_room;
    logic            idx_lt;
    logic            jdx_nz;
    logic            gt;
    logic            out_free;
  } dp_flags_t;

endpackage

FILE: sv/ale_if.sv
`timescale 1ns / 1ps
// request and response channel interfaces of the array list engine
interface ale_req_if import ale_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [POS_W-1:0]         position;
  logic signed [WORD_W-1:0] item_value;

  modport source (output valid, operation, position, item_value, input ready);
  modport sink (input valid, operation, position, item_value, output ready);
endinterface

interface ale_rsp_if import ale_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [WORD_W-1:0] read_value;
  logic [LEN_W-1:0]         list_length;
  logic                     is_empty;

  modport source (output valid, status, read_value, list_length, is_empty, input ready);
  modport sink (input valid, status, read_value, list_length, is_empty, output ready);
endinterface

FILE: sv/array_list_engine.sv
`timescale 1ns / 1ps
// array list engine: ordered list of signed q16.16 values with insert, delete and sort
//
// req_i carries one command word (operation, position, item_value); rsp_o returns
// exactly one word per command (status, read_value, list_length, is_empty).
// Both channels move a word when valid and ready are high at a rising clock edge.
// Commands run one at a time; entries live in a single ram with registered reads.
// Every command is captured, decoded and then finished by loading the response;
// clear, an invalid position, a full list and an unknown op need no more than that.
// A read adds a wait for the ram data. An insert at position p with length n moves
// entries p..n up one place and a delete moves entries p+1..n down one place, each
// with one read and one write per entry. Sort is an insertion sort: it reads each
// key in turn and moves the larger entries before it up one place.
// Each step makes one ram access at most; a read waits for its registered data.
// A finished response waits in an output register, so the next command is taken
// while the receiver stalls; a command that finishes meanwhile holds until the
// register frees. Reset empties the list; no clearing pass is needed.
module array_list_engine import ale_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ale_req_if.sink    req_i,
  ale_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  cmd_e              cmd;
  dp_flags_t         flags;
  logic              ram_we;
  logic              ram_re;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  ale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  ale_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .flags_o     (flags),
    .op_i        (req_i.operation),
    .pos_i       (req_i.position),
    .val_i       (req_i.item_value),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .rsp_o       (rsp_o)
  );

  ale_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

FILE: sv/ale_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
module ale_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/ale_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine of the array list engine
module ale_ctrl import ale_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_flags_t flags_i,
  output cmd_e      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_CAPTURE;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (flags_i.op)
          OP_CLEAR: cmd_o = CMD_CLEAR;
          OP_READ: begin
            if (flags_i.pos_bad) begin
              cmd_o = CMD_SET_RANGE;
            end else begin
              cmd_o   = CMD_RD_POS;
              state_d = S_RD_WAIT;
            end
          end
          OP_INSERT: begin
            if (flags_i.full) begin
              cmd_o = CMD_SET_FULL;
            end else if (flags_i.pos_bad_ins) begin
              cmd_o = CMD_SET_RANGE;
            end else begin
              cmd_o   = CMD_INS_INIT;
              state_d = S_INS_CHK;
            end
          end
          OP_DELETE: begin
            if (flags_i.pos_bad) begin
              cmd_o = CMD_SET_RANGE;
            end else begin
              cmd_o   = CMD_DEL_INIT;
              state_d = S_DEL_CHK;
            end
          end
          OP_SORT: begin
            cmd_o   = CMD_SORT_INIT;
            state_d = S_SORT_CHK;
          end
          default: cmd_o = CMD_NONE;
        endcase
      end
      S_RD_WAIT: begin
        cmd_o   = CMD_TAKE_RD;
        state_d = S_DONE;
      end
      S_INS_CHK: begin
        if (flags_i.idx_above) begin
          cmd_o   = CMD_SHUP_RD;
          state_d = S_INS_WR;
        end else begin
          cmd_o   = CMD_INS_PUT;
          state_d = S_DONE;
        end
      end
      S_INS_WR: begin
        cmd_o   = CMD_SHUP_WR;
        state_d = S_INS_CHK;
      end
      S_DEL_CHK: begin
        if (flags_i.idx_room) begin
          cmd_o   = CMD_SHDN_RD;
          state_d = S_DEL_WR;
        end else begin
          cmd_o   = CMD_DEL_DONE;
          state_d = S_DONE;
        end
      end
      S_DEL_WR: begin
        cmd_o   = CMD_SHDN_WR;
        state_d = S_DEL_CHK;
      end
      S_SORT_CHK: begin
        if (flags_i.idx_lt) begin
          cmd_o   = CMD_KEY_RD;
          state_d = S_KEY_WAIT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_KEY_WAIT: begin
        cmd_o   = CMD_KEY_TAKE;
        state_d = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (flags_i.jdx_nz) begin
          cmd_o   = CMD_CMP_RD;
          state_d = S_CMP;
        end else begin
          cmd_o   = CMD_KEY_PUT;
          state_d = S_SORT_CHK;
        end
      end
      S_CMP: begin
        if (flags_i.gt) begin
          cmd_o   = CMD_CMP_SHIFT;
          state_d = S_CMP_CHK;
        end else begin
          cmd_o   = CMD_KEY_PUT;
          state_d = S_SORT_CHK;
        end
      end
      S_DONE: begin
        if (flags_i.out_free) begin
          cmd_o   = CMD_FINISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DECODE))
    else $error("accepted word not followed by decode");

endmodule

FILE: sv/ale_datapath.sv
`timescale 1ns / 1ps
// registers, index counters and compare logic of the array list engine
module ale_datapath import ale_pkg::*; #(
  parameter int unsigned CAPACITY = 128
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_e                        cmd_i,
  output dp_flags_t                   flags_o,
  input  logic [OP_W-1:0]             op_i,
  input  logic [POS_W-1:0]            pos_i,
  input  logic [WORD_W-1:0]           val_i,
  output logic                        ram_we_o,
  output logic [$clog2(CAPACITY)-1:0] ram_waddr_o,
  output logic [WORD_W-1:0]           ram_wdata_o,
  output logic                        ram_re_o,
  output logic [$clog2(CAPACITY)-1:0] ram_raddr_o,
  input  logic [WORD_W-1:0]           ram_rdata_i,
  ale_rsp_if.source                   rsp_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned XW = (CW > POS_W) ? CW + 1 : POS_W + 1;

  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     idx_q, idx_d;
  logic [CW-1:0]     jdx_q, jdx_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [WORD_W-1:0] val_q, val_d;
  logic [WORD_W-1:0] key_q, key_d;
  logic [WORD_W-1:0] rdval_q, rdval_d;
  logic [STAT_W-1:0] status_q, status_d;
  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_status_q, out_status_d;
  logic [WORD_W-1:0] out_value_q, out_value_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  logic              out_empty_q, out_empty_d;

  logic [XW-1:0] pos_x, cnt_x, idx_x, posm1_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    jdx_q        <= jdx_d;
    op_q         <= op_d;
    pos_q        <= pos_d;
    val_q        <= val_d;
    key_q        <= key_d;
    rdval_q      <= rdval_d;
    status_q     <= status_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_len_q    <= out_len_d;
    out_empty_q  <= out_empty_d;
  end

  assign pos_x   = XW'(pos_q);
  assign cnt_x   = XW'(count_q);
  assign idx_x   = XW'(idx_q);
  assign posm1_x = pos_x - XW'(1);

  always_comb begin
    flags_o.op          = op_q;
    flags_o.full        = (count_q == CW'(CAPACITY));
    flags_o.pos_bad     = (pos_q == '0) || (pos_x > cnt_x);
    flags_o.pos_bad_ins = (pos_q == '0) || (pos_x > cnt_x + XW'(1));
    flags_o.idx_above   = (idx_x > posm1_x);
    flags_o.idx_room    = (idx_x + XW'(1) < cnt_x);
    flags_o.idx_lt      = (idx_q < count_q);
    flags_o.jdx_nz      = (jdx_q != '0);
    flags_o.gt          = ($signed(ram_rdata_i) > $signed(key_q));
    flags_o.out_free    = !out_valid_q || rsp_o.ready;
  end

  always_comb begin
    count_d      = count_q;
    idx_d        = idx_q;
    jdx_d        = jdx_q;
    op_d         = op_q;
    pos_d        = pos_q;
    val_d        = val_q;
    key_d        = key_q;
    rdval_d      = rdval_q;
    status_d     = status_q;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_len_d    = out_len_q;
    out_empty_d  = out_empty_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    ram_we_o     = 1'b0;
    ram_waddr_o  = '0;
    ram_wdata_o  = ram_rdata_i;
    ram_re_o     = 1'b0;
    ram_raddr_o  = '0;
    case (cmd_i)
      CMD_CAPTURE: begin
        op_d     = op_i;
        pos_d    = pos_i;
        val_d    = val_i;
        status_d = ST_OK;
        rdval_d  = '0;
      end
      CMD_CLEAR:     count_d = '0;
      CMD_SET_RANGE: status_d = ST_RANGE;
      CMD_SET_FULL:  status_d = ST_FULL;
      CMD_RD_POS: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = AW'(posm1_x);
      end
      CMD_TAKE_RD:  rdval_d = ram_rdata_i;
      CMD_INS_INIT: idx_d = count_q;
      CMD_SHUP_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = AW'(idx_q - CW'(1));
      end
      CMD_SHUP_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = AW'(idx_q);
        idx_d       = idx_q - CW'(1);
      end
      CMD_INS_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = AW'(posm1_x);
        ram_wdata_o = val_q;
        count_d     = count_q + CW'(1);
      end
      CMD_DEL_INIT: idx_d = CW'(posm1_x);
      CMD_SHDN_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = AW'(idx_q + CW'(1));
      end
      CMD_SHDN_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = AW'(idx_q);
        idx_d       = idx_q + CW'(1);
      end
      CMD_DEL_DONE:  count_d = count_q - CW'(1);
      CMD_SORT_INIT: idx_d = CW'(1);
      CMD_KEY_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = AW'(idx_q);
        jdx_d       = idx_q;
      end
      CMD_KEY_TAKE: key_d = ram_rdata_i;
      CMD_CMP_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = AW'(jdx_q - CW'(1));
      end
      CMD_CMP_SHIFT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = AW'(jdx_q);
        jdx_d       = jdx_q - CW'(1);
      end
      CMD_KEY_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = AW'(jdx_q);
        ram_wdata_o = key_q;
        idx_d       = idx_q + CW'(1);
      end
      CMD_FINISH: begin
        out_valid_d  = 1'b1;
        out_status_d = status_q;
        out_value_d  = rdval_q;
        out_len_d    = LEN_W'(count_q);
        out_empty_d  = (count_q == '0);
      end
      default: ;
    endcase
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.read_value  = out_value_q;
  assign rsp_o.list_length = out_len_q;
  assign rsp_o.is_empty    = out_empty_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("list length above capacity");

  a_put_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_INS_PUT) |-> (count_q < CW'(CAPACITY)))
    else $error("insert into full list");

  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == CMD_FINISH) |-> (!out_valid_q || rsp_o.ready))
    else $error("result word overwritten before it was taken");

endmodule
